// File: hdl/low_voltage_detector_core_macros.svh
// Assertion macros for the low-voltage detector.
// Used by lvd_detect, the module that carries concurrent checks; no dependencies.
`ifndef LOW_VOLTAGE_DETECTOR_CORE_MACROS_SVH
`define LOW_VOLTAGE_DETECTOR_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define LVD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("lvd assertion failed");
`define LVD_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("lvd assertion failed");
`else
`define LVD_ASSERT(lbl, clk, rst_n, prop)
`define LVD_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// File: hdl/lvd_pkg.sv
// Shared types, constants and the threshold table of the low-voltage detector.
// No dependencies.
package lvd_pkg;

    localparam int CTRL_W   = 8;
    localparam int SUPPLY_W = 13;
    localparam int HYST_W   = 10;
    localparam int SAT_W    = 16;
    localparam int SEL_W    = 4;

    localparam int FULL_SCALE_MV = 5000;

    localparam logic [HYST_W-1:0] HYST_RESET = 10'd100;

    localparam int CTRL_FLAG_BIT   = 0;
    localparam int CTRL_IRQ_EN_BIT = 1;
    localparam int CTRL_RSVD_BIT   = 2;
    localparam int CTRL_ENABLE_BIT = 3;
    localparam int CTRL_SEL_LSB    = 4;

    typedef struct packed {
        logic [CTRL_W-1:0] readback_byte;
        logic              irq_pulse;
        logic              below_threshold;
    } t_lvd_result;

    function automatic logic [SUPPLY_W-1:0] lvd_thresh(input logic [SEL_W-1:0] sel);
        logic [SUPPLY_W-1:0] t;
        case (sel)
            4'd0:    t = 13'd2000;
            4'd1:    t = 13'd2160;
            4'd2:    t = 13'd2310;
            4'd3:    t = 13'd2450;
            4'd4:    t = 13'd2600;
            4'd5:    t = 13'd2730;
            4'd6:    t = 13'd2880;
            4'd7:    t = 13'd2980;
            4'd8:    t = 13'd3210;
            4'd9:    t = 13'd3420;
            4'd10:   t = 13'd3620;
            4'd11:   t = 13'd3810;
            4'd12:   t = 13'd4000;
            4'd13:   t = 13'd4200;
            4'd14:   t = 13'd4430;
            default: t = 13'd4600;
        endcase
        return t;
    endfunction

endpackage

// File: hdl/lvd_if.sv
// Handshake channel interfaces: poll request, result, configuration write.
// Depends on lvd_pkg.
interface lvd_req_if;
    import lvd_pkg::*;
    logic                valid;
    logic                ready;
    logic [CTRL_W-1:0]   control_byte;
    logic [SUPPLY_W-1:0] supply_mv;
    modport source (output valid, control_byte, supply_mv, input ready);
    modport sink   (input valid, control_byte, supply_mv, output ready);
endinterface

interface lvd_rsp_if;
    import lvd_pkg::*;
    logic              valid;
    logic              ready;
    logic [CTRL_W-1:0] readback_byte;
    logic              irq_pulse;
    logic              below_threshold;
    modport source (output valid, readback_byte, irq_pulse, below_threshold, input ready);
    modport sink   (input valid, readback_byte, irq_pulse, below_threshold, output ready);
endinterface

interface lvd_cfg_if;
    import lvd_pkg::*;
    logic              valid;
    logic              ready;
    logic [HYST_W-1:0] hysteresis_mv;
    modport source (output valid, hysteresis_mv, input ready);
    modport sink   (input valid, hysteresis_mv, output ready);
endinterface

// File: hdl/lvd_detect.sv
// Threshold compare with hysteresis, undervoltage state and latched flag.
// Depends on lvd_pkg and low_voltage_detector_core_macros.svh.
`include "low_voltage_detector_core_macros.svh"

module lvd_detect (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_step,
    input  logic [lvd_pkg::HYST_W-1:0]   i_hyst,
    input  logic [lvd_pkg::CTRL_W-1:0]   i_ctrl,
    input  logic [lvd_pkg::SUPPLY_W-1:0] i_supply,
    output lvd_pkg::t_lvd_result         o_result
);
    import lvd_pkg::*;

    localparam logic [SAT_W-1:0] FULL_SCALE = SAT_W'(FULL_SCALE_MV);

    logic                r_below;
    logic                r_flag;
    logic                n_below;
    logic                n_flag;
    logic                irq;
    logic [SUPPLY_W-1:0] thresh;
    logic [SAT_W-1:0]    supply_ext;
    logic [SAT_W-1:0]    supply_sat;
    logic [SAT_W-1:0]    rearm;
    logic                is_low;

    always_comb begin
        supply_ext = SAT_W'(i_supply);
        supply_sat = (supply_ext > FULL_SCALE) ? FULL_SCALE : supply_ext;
        thresh     = lvd_thresh(i_ctrl[CTRL_SEL_LSB +: SEL_W]);
        rearm      = SAT_W'(thresh) + SAT_W'(i_hyst);
        is_low     = supply_sat < SAT_W'(thresh);

        n_flag  = r_flag & i_ctrl[CTRL_FLAG_BIT];
        n_below = r_below;
        irq     = 1'b0;
        if (!i_ctrl[CTRL_ENABLE_BIT]) begin
            n_below = is_low;
        end else if (!r_below) begin
            if (is_low) begin
                n_below = 1'b1;
                n_flag  = 1'b1;
                irq     = i_ctrl[CTRL_IRQ_EN_BIT];
            end
        end else if (supply_sat >= rearm) begin
            n_below = 1'b0;
        end
    end

    always_comb begin
        o_result.readback_byte                = i_ctrl;
        o_result.readback_byte[CTRL_FLAG_BIT] = n_flag;
        o_result.readback_byte[CTRL_RSVD_BIT] = 1'b0;
        o_result.irq_pulse                    = irq;
        o_result.below_threshold              = n_below;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_below <= 1'b0;
            r_flag  <= 1'b0;
        end else if (i_step) begin
            r_below <= n_below;
            r_flag  <= n_flag;
        end
    end

    `LVD_ASSERT(a_irq_sets_state, i_clk, i_rst_n, (i_step && irq) |=> (r_below && r_flag))
    `LVD_ASSERT(a_irq_on_edge_only, i_clk, i_rst_n, (i_step && irq) |-> !r_below)
    `LVD_ASSERT(a_no_irq_disabled, i_clk, i_rst_n, !i_ctrl[CTRL_ENABLE_BIT] |-> !irq)
    `LVD_ASSERT(a_hold_idle, i_clk, i_rst_n, !i_step |=> ($stable(r_below) && $stable(r_flag)))

endmodule

// File: hdl/low_voltage_detector_core.sv
// Low-voltage detector core: input register, compare logic, result register.
// Input register, then result register; one request per cycle while results are taken.
// The result register frees as it is taken, so a new request is taken while one waits.
// Synchronous active-low reset clears valids, undervoltage state and flag; hysteresis = 100.
// Depends on lvd_pkg, lvd_if and lvd_detect.
module low_voltage_detector_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lvd_req_if.sink   i_req,
    lvd_cfg_if.sink   i_cfg,
    lvd_rsp_if.source o_rsp
);
    import lvd_pkg::*;

    logic                r_in_valid;
    logic [CTRL_W-1:0]   r_in_ctrl;
    logic [SUPPLY_W-1:0] r_in_supply;
    logic                r_out_valid;
    t_lvd_result         r_out;
    logic [HYST_W-1:0]   r_hyst;
    t_lvd_result         result;
    logic                out_load;
    logic                step;
    logic                in_ready;

    assign out_load = !r_out_valid || o_rsp.ready;
    assign step     = r_in_valid && out_load;
    assign in_ready = !r_in_valid || step;

    assign i_req.ready = in_ready;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hyst <= HYST_RESET;
        end else if (i_cfg.valid) begin
            r_hyst <= i_cfg.hysteresis_mv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_req.valid) begin
            r_in_ctrl   <= i_req.control_byte;
            r_in_supply <= i_req.supply_mv;
        end
    end

    lvd_detect u_detect (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_hyst   (r_hyst),
        .i_ctrl   (r_in_ctrl),
        .i_supply (r_in_supply),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= result;
        end
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.readback_byte   = r_out.readback_byte;
    assign o_rsp.irq_pulse       = r_out.irq_pulse;
    assign o_rsp.below_threshold = r_out.below_threshold;

endmodule
